[sv/bzp_pkg.sv]
// bzp_pkg: shared widths, types, step tables and status structs for the
// quadratic bezier point generator; used by every module in sv/
package bzp_pkg;

   // field widths
   localparam int COORD_BITS  = 24;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int SEG_BITS    = 7;
   localparam int INDEX_BITS  = 6;
   localparam int FRAC_BITS   = 16;
   localparam int FRAC_ONE    = 1 << FRAC_BITS;
   localparam int STEP_BITS   = FRAC_BITS + 1;
   localparam int PROD_BITS   = STEP_BITS + DIFF_BITS;

   // segment count limits
   localparam int MAX_SEGMENTS = 64;
   localparam int RESULT_CAP   = 64;
   localparam int SEG_CAP      = (MAX_SEGMENTS < RESULT_CAP) ? MAX_SEGMENTS : RESULT_CAP;
   localparam int TABLE_BITS   = $clog2(RESULT_CAP);

   // request queue
   localparam int QUEUE_DEPTH = 2;

   // stream word layout
   localparam int REQ_FIELD_BITS = 9 * COORD_BITS + SEG_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 3 * COORD_BITS + INDEX_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RSP_FIELD_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic [SEG_BITS-1:0]          seg_type;
   typedef logic [INDEX_BITS-1:0]        index_type;
   typedef logic [STEP_BITS-1:0]         step_type;
   typedef logic [FRAC_BITS-1:0]         frac_type;
   typedef logic [TABLE_BITS-1:0]        table_idx_type;

   // one queued curve: control points as x, y, z and the clamped count
   typedef struct packed {
      coord_type [2:0] p0;
      coord_type [2:0] p1;
      coord_type [2:0] p2;
      seg_type         segments;
   } curve_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic    running;
      logic    issue;
      seg_type idx;
      seg_type total;
   } back_status_type;

   // per-point increment of t for n = index + 1: quotient of FRAC_ONE / n
   localparam step_type STEP_QUO [RESULT_CAP] = '{
      step_type'(FRAC_ONE / 1),  step_type'(FRAC_ONE / 2),  step_type'(FRAC_ONE / 3),
      step_type'(FRAC_ONE / 4),  step_type'(FRAC_ONE / 5),  step_type'(FRAC_ONE / 6),
      step_type'(FRAC_ONE / 7),  step_type'(FRAC_ONE / 8),  step_type'(FRAC_ONE / 9),
      step_type'(FRAC_ONE / 10), step_type'(FRAC_ONE / 11), step_type'(FRAC_ONE / 12),
      step_type'(FRAC_ONE / 13), step_type'(FRAC_ONE / 14), step_type'(FRAC_ONE / 15),
      step_type'(FRAC_ONE / 16), step_type'(FRAC_ONE / 17), step_type'(FRAC_ONE / 18),
      step_type'(FRAC_ONE / 19), step_type'(FRAC_ONE / 20), step_type'(FRAC_ONE / 21),
      step_type'(FRAC_ONE / 22), step_type'(FRAC_ONE / 23), step_type'(FRAC_ONE / 24),
      step_type'(FRAC_ONE / 25), step_type'(FRAC_ONE / 26), step_type'(FRAC_ONE / 27),
      step_type'(FRAC_ONE / 28), step_type'(FRAC_ONE / 29), step_type'(FRAC_ONE / 30),
      step_type'(FRAC_ONE / 31), step_type'(FRAC_ONE / 32), step_type'(FRAC_ONE / 33),
      step_type'(FRAC_ONE / 34), step_type'(FRAC_ONE / 35), step_type'(FRAC_ONE / 36),
      step_type'(FRAC_ONE / 37), step_type'(FRAC_ONE / 38), step_type'(FRAC_ONE / 39),
      step_type'(FRAC_ONE / 40), step_type'(FRAC_ONE / 41), step_type'(FRAC_ONE / 42),
      step_type'(FRAC_ONE / 43), step_type'(FRAC_ONE / 44), step_type'(FRAC_ONE / 45),
      step_type'(FRAC_ONE / 46), step_type'(FRAC_ONE / 47), step_type'(FRAC_ONE / 48),
      step_type'(FRAC_ONE / 49), step_type'(FRAC_ONE / 50), step_type'(FRAC_ONE / 51),
      step_type'(FRAC_ONE / 52), step_type'(FRAC_ONE / 53), step_type'(FRAC_ONE / 54),
      step_type'(FRAC_ONE / 55), step_type'(FRAC_ONE / 56), step_type'(FRAC_ONE / 57),
      step_type'(FRAC_ONE / 58), step_type'(FRAC_ONE / 59), step_type'(FRAC_ONE / 60),
      step_type'(FRAC_ONE / 61), step_type'(FRAC_ONE / 62), step_type'(FRAC_ONE / 63),
      step_type'(FRAC_ONE / 64)
   };

   // matching remainder of FRAC_ONE / n, always below n
   localparam seg_type STEP_REM [RESULT_CAP] = '{
      seg_type'(FRAC_ONE % 1),  seg_type'(FRAC_ONE % 2),  seg_type'(FRAC_ONE % 3),
      seg_type'(FRAC_ONE % 4),  seg_type'(FRAC_ONE % 5),  seg_type'(FRAC_ONE % 6),
      seg_type'(FRAC_ONE % 7),  seg_type'(FRAC_ONE % 8),  seg_type'(FRAC_ONE % 9),
      seg_type'(FRAC_ONE % 10), seg_type'(FRAC_ONE % 11), seg_type'(FRAC_ONE % 12),
      seg_type'(FRAC_ONE % 13), seg_type'(FRAC_ONE % 14), seg_type'(FRAC_ONE % 15),
      seg_type'(FRAC_ONE % 16), seg_type'(FRAC_ONE % 17), seg_type'(FRAC_ONE % 18),
      seg_type'(FRAC_ONE % 19), seg_type'(FRAC_ONE % 20), seg_type'(FRAC_ONE % 21),
      seg_type'(FRAC_ONE % 22), seg_type'(FRAC_ONE % 23), seg_type'(FRAC_ONE % 24),
      seg_type'(FRAC_ONE % 25), seg_type'(FRAC_ONE % 26), seg_type'(FRAC_ONE % 27),
      seg_type'(FRAC_ONE % 28), seg_type'(FRAC_ONE % 29), seg_type'(FRAC_ONE % 30),
      seg_type'(FRAC_ONE % 31), seg_type'(FRAC_ONE % 32), seg_type'(FRAC_ONE % 33),
      seg_type'(FRAC_ONE % 34), seg_type'(FRAC_ONE % 35), seg_type'(FRAC_ONE % 36),
      seg_type'(FRAC_ONE % 37), seg_type'(FRAC_ONE % 38), seg_type'(FRAC_ONE % 39),
      seg_type'(FRAC_ONE % 40), seg_type'(FRAC_ONE % 41), seg_type'(FRAC_ONE % 42),
      seg_type'(FRAC_ONE % 43), seg_type'(FRAC_ONE % 44), seg_type'(FRAC_ONE % 45),
      seg_type'(FRAC_ONE % 46), seg_type'(FRAC_ONE % 47), seg_type'(FRAC_ONE % 48),
      seg_type'(FRAC_ONE % 49), seg_type'(FRAC_ONE % 50), seg_type'(FRAC_ONE % 51),
      seg_type'(FRAC_ONE % 52), seg_type'(FRAC_ONE % 53), seg_type'(FRAC_ONE % 54),
      seg_type'(FRAC_ONE % 55), seg_type'(FRAC_ONE % 56), seg_type'(FRAC_ONE % 57),
      seg_type'(FRAC_ONE % 58), seg_type'(FRAC_ONE % 59), seg_type'(FRAC_ONE % 60),
      seg_type'(FRAC_ONE % 61), seg_type'(FRAC_ONE % 62), seg_type'(FRAC_ONE % 63),
      seg_type'(FRAC_ONE % 64)
   };

endpackage

[sv/bzp_front.sv]
// bzp_front: request intake; unpacks the request word and clamps the count
// depends on bzp_pkg
module bzp_front (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bzp_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input  bzp_pkg::queue_status_type            q_status,
   output logic                                 push,
   output bzp_pkg::curve_type                   push_data
);

   localparam int CB = bzp_pkg::COORD_BITS;

   bzp_pkg::seg_type raw_seg;

   // accept whenever the queue has room
   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   assign raw_seg = req_tdata[9*CB +: bzp_pkg::SEG_BITS];

   // unpack control points, clamp count to 1 .. cap
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         push_data.p0[k] = req_tdata[k*CB +: CB];
         push_data.p1[k] = req_tdata[(3+k)*CB +: CB];
         push_data.p2[k] = req_tdata[(6+k)*CB +: CB];
      end
      if (raw_seg == '0) begin
         push_data.segments = bzp_pkg::seg_type'(1);
      end else if (raw_seg > bzp_pkg::seg_type'(bzp_pkg::SEG_CAP)) begin
         push_data.segments = bzp_pkg::seg_type'(bzp_pkg::SEG_CAP);
      end else begin
         push_data.segments = raw_seg;
      end
   end

endmodule

[sv/bzp_queue.sv]
// bzp_queue: short fifo of accepted curves between intake and point engine
// depends on bzp_pkg
module bzp_queue #(
   parameter int DEPTH = bzp_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bzp_pkg::curve_type         push_data,
   input  logic                       pop,
   output bzp_pkg::curve_type         pop_data,
   output bzp_pkg::queue_status_type  status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   bzp_pkg::curve_type  entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff,  count_in;

   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/bzp_back.sv]
// bzp_back: point engine; steps t per curve and runs the three lerps
// through a four-stage pipeline into the output register; depends on bzp_pkg
module bzp_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bzp_pkg::curve_type                   head,
   input  bzp_pkg::queue_status_type            q_status,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bzp_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   output bzp_pkg::back_status_type             status
);

   localparam int CB = bzp_pkg::COORD_BITS;
   localparam int FB = bzp_pkg::FRAC_BITS;
   localparam int DB = bzp_pkg::DIFF_BITS;
   localparam int PB = bzp_pkg::PROD_BITS;
   localparam int SB = bzp_pkg::SEG_BITS;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type             state_ff, state_in;
   bzp_pkg::seg_type      idx_ff, idx_in;
   bzp_pkg::seg_type      total_ff, total_in;
   bzp_pkg::seg_type      acc_ff, acc_in;
   bzp_pkg::seg_type      rem_ff, rem_in;
   bzp_pkg::step_type     quo_ff, quo_in;
   bzp_pkg::step_type     t_ff, t_in;

   logic                  en, issue, last_issue;
   logic [SB:0]           rem_sum;
   bzp_pkg::table_idx_type tbl_idx;
   bzp_pkg::frac_type     t_cur;

   // curve registers, loaded when a curve is taken from the queue
   bzp_pkg::coord_type    base0_ff [3];
   bzp_pkg::coord_type    base1_ff [3];
   bzp_pkg::diff_type     diff0_ff [3];
   bzp_pkg::diff_type     diff1_ff [3];

   // stage a: first pair of products
   logic                  a_vld_ff;
   bzp_pkg::prod_type     a_prod0_ff [3], a_prod0_in [3];
   bzp_pkg::prod_type     a_prod1_ff [3], a_prod1_in [3];
   bzp_pkg::coord_type    a_base0_ff [3];
   bzp_pkg::coord_type    a_base1_ff [3];
   bzp_pkg::frac_type     a_t_ff;
   bzp_pkg::index_type    a_idx_ff;
   logic                  a_last_ff;

   // stage b: midpoints and their difference
   logic                  b_vld_ff;
   bzp_pkg::coord_type    b_m0_ff [3], b_m0_in [3];
   bzp_pkg::diff_type     b_diff_ff [3], b_diff_in [3];
   bzp_pkg::frac_type     b_t_ff;
   bzp_pkg::index_type    b_idx_ff;
   logic                  b_last_ff;

   // stage c: final product
   logic                  c_vld_ff;
   bzp_pkg::prod_type     c_prod_ff [3], c_prod_in [3];
   bzp_pkg::coord_type    c_m0_ff [3];
   bzp_pkg::index_type    c_idx_ff;
   logic                  c_last_ff;

   // output register
   logic                  out_vld_ff;
   bzp_pkg::coord_type    out_pt_ff [3], out_pt_in [3];
   bzp_pkg::index_type    out_idx_ff;
   logic                  out_last_ff;

   // whole pipeline moves when the output word is free or being taken
   assign en         = !out_vld_ff || rsp_tready;
   assign issue      = (state_ff == ST_RUN) && en;
   assign last_issue = (idx_ff == total_ff - bzp_pkg::seg_type'(1));
   assign pop        = (state_ff == ST_IDLE) && !q_status.empty;
   assign rem_sum    = {1'b0, acc_ff} + {1'b0, rem_ff};
   assign t_cur      = t_ff[FB-1:0];
   assign tbl_idx    = bzp_pkg::table_idx_type'(head.segments - bzp_pkg::seg_type'(1));

   assign status.running = (state_ff == ST_RUN);
   assign status.issue   = issue;
   assign status.idx     = idx_ff;
   assign status.total   = total_ff;

   // sequencer: t steps by quotient, remainder carried with one compare
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      t_in     = t_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               state_in = ST_RUN;
               total_in = head.segments;
               idx_in   = '0;
               acc_in   = '0;
               t_in     = '0;
               quo_in   = bzp_pkg::STEP_QUO[tbl_idx];
               rem_in   = bzp_pkg::STEP_REM[tbl_idx];
            end
         end
         ST_RUN: begin
            if (en) begin
               idx_in = idx_ff + bzp_pkg::seg_type'(1);
               if (rem_sum >= {1'b0, total_ff}) begin
                  acc_in = bzp_pkg::seg_type'(rem_sum - {1'b0, total_ff});
                  t_in   = t_ff + quo_ff + bzp_pkg::step_type'(1);
               end else begin
                  acc_in = bzp_pkg::seg_type'(rem_sum);
                  t_in   = t_ff + quo_ff;
               end
               if (last_issue) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         total_ff <= '0;
         acc_ff   <= '0;
         rem_ff   <= '0;
         quo_ff   <= '0;
         t_ff     <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         total_ff <= total_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         t_ff     <= t_in;
      end
   end

   // latch control points and the two constant differences
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int k = 0; k < 3; k++) begin
            base0_ff[k] <= $signed(head.p0[k]);
            base1_ff[k] <= $signed(head.p1[k]);
            diff0_ff[k] <= DB'($signed(head.p1[k])) - DB'($signed(head.p0[k]));
            diff1_ff[k] <= DB'($signed(head.p2[k])) - DB'($signed(head.p1[k]));
         end
      end
   end

   // datapath for the three stages and the output
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_prod0_in[k] = PB'($signed({1'b0, t_cur})) * PB'(diff0_ff[k]);
         a_prod1_in[k] = PB'($signed({1'b0, t_cur})) * PB'(diff1_ff[k]);
         // floor division by FRAC_ONE is the upper bits of the product
         b_m0_in[k]    = a_base0_ff[k] + a_prod0_ff[k][FB +: CB];
         b_diff_in[k]  = DB'($signed(a_base1_ff[k] + a_prod1_ff[k][FB +: CB]))
                         - DB'(b_m0_in[k]);
         c_prod_in[k]  = PB'($signed({1'b0, b_t_ff})) * PB'(b_diff_ff[k]);
         out_pt_in[k]  = c_m0_ff[k] + c_prod_ff[k][FB +: CB];
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff   <= issue;
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;
         out_vld_ff <= c_vld_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            a_prod0_ff[k] <= a_prod0_in[k];
            a_prod1_ff[k] <= a_prod1_in[k];
            a_base0_ff[k] <= base0_ff[k];
            a_base1_ff[k] <= base1_ff[k];
            b_m0_ff[k]    <= b_m0_in[k];
            b_diff_ff[k]  <= b_diff_in[k];
            c_prod_ff[k]  <= c_prod_in[k];
            c_m0_ff[k]    <= b_m0_ff[k];
            out_pt_ff[k]  <= out_pt_in[k];
         end
         a_t_ff      <= t_cur;
         a_idx_ff    <= bzp_pkg::index_type'(idx_ff);
         a_last_ff   <= last_issue;
         b_t_ff      <= a_t_ff;
         b_idx_ff    <= a_idx_ff;
         b_last_ff   <= a_last_ff;
         c_idx_ff    <= b_idx_ff;
         c_last_ff   <= b_last_ff;
         out_idx_ff  <= c_idx_ff;
         out_last_ff <= c_last_ff;
      end
   end

   // result word
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{bzp_pkg::RSP_PAD_BITS{1'b0}}, out_idx_ff,
                        out_pt_ff[2], out_pt_ff[1], out_pt_ff[0]};

endmodule

[sv/quadratic_bezier_point_generator.sv]
// quadratic_bezier_point_generator: top level; intake, curve queue and point engine
// depends on bzp_pkg, bzp_front, bzp_queue, bzp_back
//
//  channel  dir  handshake              word contents (low bit first)
//  req      in   req_tvalid/req_tready  start xyz, ctrl xyz, end xyz, segments
//  rsp      out  rsp_tvalid/rsp_tready  point xyz, point_index; rsp_tlast = last point
//
// the point engine takes a curve while idle, loading the step table entry and
// control point differences, then issues one point per cycle from the t stepper
// unless the output stalls; each point passes stages a, b, c to the output register.
// reset is synchronous and clears the queue, sequencer and pipeline valids.
// a stalled result holds the whole point pipeline; the queue keeps taking
// requests until QUEUE_DEPTH curves wait.
module quadratic_bezier_point_generator #(
   parameter int QUEUE_DEPTH = bzp_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // start_x, start_y, start_z, ctrl_x, ctrl_y, ctrl_z, end_x, end_y, end_z, segments
   input  logic [bzp_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // point_x, point_y, point_z, point_index
   output logic [bzp_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast
);

   logic                       push, pop;
   bzp_pkg::curve_type         push_data, head;
   bzp_pkg::queue_status_type  q_status;
   bzp_pkg::back_status_type   back_status;

   bzp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   bzp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (head),
      .status    (q_status)
   );

   bzp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .status     (back_status)
   );

   // issue index stays inside the curve
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      back_status.running |-> (back_status.idx < back_status.total))
      else $error("point index ran past the segment count");

   // a running curve has a clamped count
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      back_status.running |-> (back_status.total != '0) &&
         (back_status.total <= bzp_pkg::seg_type'(bzp_pkg::SEG_CAP)))
      else $error("segment count outside 1 .. cap");

   // the engine stops after issuing the last point
   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      back_status.issue && (back_status.idx == back_status.total - bzp_pkg::seg_type'(1))
      |=> !back_status.running)
      else $error("engine kept running after the last point");

   // a curve starts only from a queued request
   a_start_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(back_status.running) |-> $past(!q_status.empty))
      else $error("engine started with an empty queue");

endmodule

[verif/testbench.sv]
// testbench for quadratic_bezier_point_generator: drives curve requests, tracks
// the expected curve points in a scoreboard class and checks every result word
// depends on bzp_pkg and the rtl in sv/
`timescale 1ns / 100ps

module testbench;

   localparam int CB        = bzp_pkg::COORD_BITS;
   localparam int REQ_BITS  = bzp_pkg::REQ_FIELD_BITS;
   localparam int REQ_WORD  = bzp_pkg::REQ_TDATA_BITS;
   localparam int COORD_MIN = -(1 << (CB - 1));
   localparam int COORD_MAX = (1 << (CB - 1)) - 1;

   // one curve request, packed as it travels in req_tdata
   typedef struct packed {
      bzp_pkg::seg_type            segments;
      bzp_pkg::coord_type [8:0]    pts;
   } curve_request_type;

   // one expected curve point
   typedef struct packed {
      logic                        last;
      bzp_pkg::index_type          idx;
      bzp_pkg::coord_type [2:0]    pos;
   } curve_point_type;

   // predicts the points of each accepted curve and checks result words in order
   class curve_point_tracker;
      curve_point_type pending_points [$];
      int unsigned     errors = 0;

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // one lerp step, floored toward negative infinity
      static function longint lerp(longint a, longint b, longint t);
         return a + ((t * (b - a)) >>> bzp_pkg::FRAC_BITS);
      endfunction

      function void note_request(curve_request_type r);
         int unsigned     n;
         longint          t;
         longint          m0;
         longint          m1;
         curve_point_type p;
         n = 32'(r.segments);
         // zero segments means one point, too many saturate at the cap
         if (n < 1) n = 1;
         if (n > bzp_pkg::SEG_CAP) n = bzp_pkg::SEG_CAP;
         for (int unsigned i = 0; i < n; i++) begin
            t = longint'((i * bzp_pkg::FRAC_ONE) / n);
            for (int k = 0; k < 3; k++) begin
               m0 = lerp(longint'($signed(r.pts[k])), longint'($signed(r.pts[3+k])), t);
               m1 = lerp(longint'($signed(r.pts[3+k])), longint'($signed(r.pts[6+k])), t);
               p.pos[k] = bzp_pkg::coord_type'(lerp(m0, m1, t));
            end
            p.idx  = bzp_pkg::index_type'(i);
            p.last = (i + 1 == n);
            pending_points.push_back(p);
         end
      endfunction

      task check_point(logic [bzp_pkg::RSP_TDATA_BITS-1:0] data, logic last);
         curve_point_type    want;
         bzp_pkg::coord_type got;
         bzp_pkg::index_type got_idx;
         if (pending_points.size() == 0) begin
            report($sformatf("point word %h with nothing expected", data));
            return;
         end
         want = pending_points.pop_front();
         for (int k = 0; k < 3; k++) begin
            got = data[k*CB +: CB];
            if (got !== want.pos[k])
               report($sformatf("point %0d axis %0d: got %0d want %0d",
                                want.idx, k, got, want.pos[k]));
         end
         got_idx = data[3*CB +: bzp_pkg::INDEX_BITS];
         if (got_idx !== want.idx)
            report($sformatf("point_index: got %0d want %0d", got_idx, want.idx));
         if (last !== want.last)
            report($sformatf("point %0d last flag: got %b want %b",
                             want.idx, last, want.last));
      endtask
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   // start_x, start_y, start_z, ctrl_x, ctrl_y, ctrl_z, end_x, end_y, end_z, segments
   logic [REQ_WORD-1:0]                  req_tdata;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready;
   // point_x, point_y, point_z, point_index
   logic [bzp_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata;
   logic                                 rsp_tlast;

   curve_point_tracker points_sb = new();
   bit                 req_idle_on = 1'b1;
   bit                 rsp_idle_on = 1'b1;
   int unsigned        stall_left = 0;

   quadratic_bezier_point_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side ready with random stall bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(1, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result word monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         points_sb.check_point(rsp_tdata, rsp_tlast);
   end

   // offer one request word, hold it until it is taken
   task automatic send_request(curve_request_type r);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_WORD'(r);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      points_sb.note_request(r);
   endtask

   function automatic curve_request_type make_curve(int sx, int sy, int sz,
                                                     int cx, int cy, int cz,
                                                     int ex, int ey, int ez, int seg);
      curve_request_type r;
      int                pt [9];
      pt = '{sx, sy, sz, cx, cy, cz, ex, ey, ez};
      for (int k = 0; k < 9; k++) r.pts[k] = bzp_pkg::coord_type'(pt[k]);
      r.segments = bzp_pkg::seg_type'(seg);
      return r;
   endfunction

   function automatic bzp_pkg::coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: return bzp_pkg::coord_type'(COORD_MIN);
         1: return bzp_pkg::coord_type'(COORD_MAX);
         2: return bzp_pkg::coord_type'(int'($urandom_range(0, 2000)) - 1000);
         default: return bzp_pkg::coord_type'($urandom);
      endcase
   endfunction

   // mostly small counts, some zero, a few at and past the cap
   function automatic bzp_pkg::seg_type rand_segments();
      case ($urandom_range(0, 19))
         0: return bzp_pkg::seg_type'(0);
         1: return bzp_pkg::seg_type'($urandom_range(bzp_pkg::SEG_CAP + 1, 127));
         2, 3: return bzp_pkg::seg_type'($urandom_range(17, bzp_pkg::SEG_CAP));
         4: return bzp_pkg::seg_type'(bzp_pkg::SEG_CAP);
         default: return bzp_pkg::seg_type'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic curve_request_type rand_curve();
      curve_request_type  r;
      bzp_pkg::coord_type base;
      case ($urandom_range(0, 9))
         // raw noise over the whole word
         0, 1: r = curve_request_type'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom}));
         // compact curve around one spot
         2, 3, 4: begin
            for (int k = 0; k < 9; k++) begin
               if (k % 3 == 0 || k < 3) base = rand_coord();
               r.pts[k] = (k < 3) ? base
                        : bzp_pkg::coord_type'(r.pts[k%3] + int'($urandom_range(0, 8000))
                                               - 4000);
            end
            r.segments = rand_segments();
         end
         default: begin
            for (int k = 0; k < 9; k++) r.pts[k] = rand_coord();
            r.segments = rand_segments();
         end
      endcase
      return r;
   endfunction

   // main sequence
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero count, saturation, negative floors
      send_request(make_curve(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send_request(make_curve(5, -5, 7, 100, 200, 300, -9, 9, -9, 0));
      send_request(make_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 64));
      send_request(make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 63));
      send_request(make_curve(-1, -1, -1, -1, -1, -1, -1, -1, -1, 2));
      send_request(make_curve(COORD_MIN, COORD_MAX, 0, COORD_MIN, 0, COORD_MAX,
                              COORD_MAX, COORD_MIN, -1, 127));
      send_request(make_curve(10, 20, 30, 40, 50, 60, 70, 80, 90, 65));
      send_request(make_curve(10, -10, 3, -7, 7, -3, 3, -3, 1, 3));
      send_request(make_curve(0, 0, 0, 1000, -1000, 500, 2000, -2000, 1000, 7));
      send_request(make_curve(-3, 3, -1, -4, 4, -2, -5, 5, -3, 5));
      send_request(make_curve(COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0,
                              COORD_MIN, COORD_MAX, COORD_MIN, 11));
      send_request(make_curve(256, -256, 512, -512, 768, -768, 1024, -1024, 0, 16));
      send_request(make_curve(1, 2, 3, 4, 5, 6, 7, 8, 9, 1));
      send_request(make_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 32));

      // random part, quiet stretches inside and none at all at the end
      for (int n = 0; n < 356; n++) begin
         req_idle_on = (n < 316) && (n % 80 < 60);
         rsp_idle_on = req_idle_on;
         send_request(rand_curve());
      end
      req_tvalid <= 1'b0;

      // drain
      while (points_sb.pending_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (points_sb.errors == 0 && points_sb.pending_points.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule

[sim.f]
sv/bzp_pkg.sv
sv/bzp_front.sv
sv/bzp_queue.sv
sv/bzp_back.sv
sv/quadratic_bezier_point_generator.sv
verif/testbench.sv
